@@ rtl/core/owmf_pkg.sv @@
package owmf_pkg;

  // Pool geometry
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_BYTES = 64;

  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
  localparam int SUM_W     = $clog2(2 * SLOT_COUNT);
  localparam int OFF_W     = $clog2(SLOT_BYTES + 1);
  localparam int MEM_DEPTH = SLOT_COUNT * SLOT_BYTES;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Fixed field widths
  localparam int DATA_W     = 8;
  localparam int LEN_W      = 7;
  localparam int MAXLEN_W   = 7;
  localparam int SLOTS_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 7'd64;
  localparam logic [SLOTS_W-1:0]  SLOTS_RESET   = 4'd8;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result status codes
  localparam logic STATUS_DATA  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LEN    = 1'b0,
    CFG_SLOTS_USED = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DATA_W-1:0] data;
    logic              byte_valid;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] out_byte;
    logic              out_valid;
    logic [LEN_W-1:0]  msg_length;
    logic              end_of_msg;
  } res_t;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_STREAM = 1'b1
  } back_state_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (32'(s) + 32'd1 >= 32'(SLOT_COUNT)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [OFF_W-1:0]  off);
    return ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off);
  endfunction

endpackage

@@ rtl/core/owmf_req_if.sv @@
interface owmf_req_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [owmf_pkg::DATA_W-1:0]    data;
  logic                           byte_valid;
  logic                           last;

  modport source (output valid, func, data, byte_valid, last, input ready);
  modport sink   (input valid, func, data, byte_valid, last, output ready);
endinterface

@@ rtl/core/owmf_rsp_if.sv @@
interface owmf_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [owmf_pkg::DATA_W-1:0]    out_byte;
  logic                           out_valid;
  logic [owmf_pkg::LEN_W-1:0]     msg_length;
  logic                           end_of_msg;

  modport source (output valid, status, out_byte, out_valid, msg_length, end_of_msg,
                  input ready);
  modport sink   (input valid, status, out_byte, out_valid, msg_length, end_of_msg,
                  output ready);
endinterface

@@ rtl/core/owmf_cfg_if.sv @@
interface owmf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [owmf_pkg::CFG_IDX_W-1:0]    index;
  logic [owmf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/owmf_front.sv @@
module owmf_front (
  input  logic           clk,
  input  logic           rst,
  owmf_req_if.sink       req,
  output logic           cmd_valid,
  output owmf_pkg::cmd_t cmd,
  input  logic           cmd_ready
);

  logic           hold_v;
  owmf_pkg::cmd_t hold_cmd;
  logic           accept;
  logic           is_nop;

  // Take a request whenever the holding stage is free or draining
  assign req.ready = !hold_v || cmd_ready;
  assign accept    = req.valid && req.ready;

  // Drop a push request that carries neither a byte nor the last flag
  assign is_nop = !req.func && !req.byte_valid && !req.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (req.ready) begin
      hold_v <= accept && !is_nop;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd.kind       <= req.func ? owmf_pkg::CMD_POP : owmf_pkg::CMD_PUSH;
      hold_cmd.data       <= req.data;
      hold_cmd.byte_valid <= req.byte_valid;
      hold_cmd.last       <= req.last;
    end
  end

  assign cmd_valid = hold_v;
  assign cmd       = hold_cmd;

endmodule

@@ rtl/core/owmf_queue.sv @@
module owmf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  owmf_pkg::cmd_t in_cmd,
  output logic           in_ready,
  output logic           out_valid,
  output owmf_pkg::cmd_t out_cmd,
  input  logic           out_ready
);

  owmf_pkg::cmd_t                  entries [owmf_pkg::QDEPTH];
  logic [owmf_pkg::QPTR_W-1:0]     wp;
  logic [owmf_pkg::QPTR_W-1:0]     rp;
  logic [owmf_pkg::QCNT_W-1:0]     cnt;
  logic                            push;
  logic                            pop;

  assign in_ready  = cnt != owmf_pkg::QCNT_W'(owmf_pkg::QDEPTH);
  assign out_valid = cnt != '0;
  assign out_cmd   = entries[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (32'(wp) == owmf_pkg::QDEPTH - 1) ? '0 : wp + owmf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rp <= (32'(rp) == owmf_pkg::QDEPTH - 1) ? '0 : rp + owmf_pkg::QPTR_W'(1);
      end
      cnt <= cnt + owmf_pkg::QCNT_W'(push) - owmf_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= in_cmd;
    end
  end

endmodule

@@ rtl/core/owmf_back.sv @@
module owmf_back (
  input  logic           clk,
  input  logic           rst,
  owmf_cfg_if.sink       cfg,
  input  logic           cmd_valid,
  input  owmf_pkg::cmd_t cmd,
  output logic           cmd_ready,
  owmf_rsp_if.source     rsp
);

  // Configuration
  logic [owmf_pkg::MAXLEN_W-1:0] max_len;
  logic [owmf_pkg::SLOTS_W-1:0]  slots_used;

  // Ring bookkeeping
  logic [owmf_pkg::SLOT_W-1:0] head_slot;
  logic [owmf_pkg::SLOT_W-1:0] tail_slot;
  logic [owmf_pkg::CNT_W-1:0]  stored_count;
  logic [owmf_pkg::OFF_W-1:0]  write_offset;
  logic                        in_message;

  // Stores
  logic [owmf_pkg::DATA_W-1:0] byte_store   [owmf_pkg::MEM_DEPTH];
  logic [owmf_pkg::OFF_W-1:0]  length_store [owmf_pkg::SLOT_COUNT];

  // Stream state
  owmf_pkg::back_state_t       state;
  owmf_pkg::back_state_t       state_next;
  logic [owmf_pkg::SLOT_W-1:0] rd_slot;
  logic [owmf_pkg::OFF_W-1:0]  rd_idx;
  logic [owmf_pkg::OFF_W-1:0]  rd_len;
  logic                        rd_pend;
  logic                        rd_end;
  logic [owmf_pkg::DATA_W-1:0] rd_data;

  // Two-entry result buffer
  owmf_pkg::res_t o_buf [2];
  logic           o_wp;
  logic           o_rp;
  logic [1:0]     o_cnt;
  logic           o_pop;
  logic           o_room;
  logic           o_we;
  owmf_pkg::res_t o_wdata;

  // Derived values
  logic [owmf_pkg::CNT_W-1:0]  cap;
  logic [owmf_pkg::OFF_W-1:0]  eff_len;
  logic                        opening;
  logic                        drop;
  logic [owmf_pkg::SUM_W-1:0]  head_sum;
  logic [owmf_pkg::SLOT_W-1:0] head_drop;
  logic [owmf_pkg::CNT_W-1:0]  cnt_base;
  logic [owmf_pkg::OFF_W-1:0]  off_base;
  logic [owmf_pkg::OFF_W-1:0]  off_after;
  logic                        keep;
  logic                        pop_empty;
  logic [owmf_pkg::OFF_W-1:0]  pop_len;
  logic                        stream_end;
  logic                        can_issue;

  // Control outputs of the sequencer
  logic do_push;
  logic do_pop;
  logic direct_we;
  logic issue;

  assign cfg.ready = 1'b1;

  // Clamp configuration to the pool
  always_comb begin
    if (slots_used == '0) begin
      cap = owmf_pkg::CNT_W'(1);
    end else if (32'(slots_used) > 32'(owmf_pkg::SLOT_COUNT)) begin
      cap = owmf_pkg::CNT_W'(owmf_pkg::SLOT_COUNT);
    end else begin
      cap = owmf_pkg::CNT_W'(slots_used);
    end
    if (32'(max_len) > 32'(owmf_pkg::SLOT_BYTES)) begin
      eff_len = owmf_pkg::OFF_W'(owmf_pkg::SLOT_BYTES);
    end else begin
      eff_len = owmf_pkg::OFF_W'(max_len);
    end
  end

  // Push: drop the oldest messages at a message start, place the byte
  always_comb begin
    opening  = !in_message;
    drop     = opening && (stored_count >= cap);
    head_sum = owmf_pkg::SUM_W'(head_slot)
             + owmf_pkg::SUM_W'(stored_count - cap + owmf_pkg::CNT_W'(1));
    if (head_sum >= owmf_pkg::SUM_W'(owmf_pkg::SLOT_COUNT)) begin
      head_drop = owmf_pkg::SLOT_W'(head_sum - owmf_pkg::SUM_W'(owmf_pkg::SLOT_COUNT));
    end else begin
      head_drop = owmf_pkg::SLOT_W'(head_sum);
    end
    cnt_base  = drop ? cap - owmf_pkg::CNT_W'(1) : stored_count;
    off_base  = opening ? '0 : write_offset;
    keep      = cmd.byte_valid && (off_base < eff_len);
    off_after = keep ? off_base + owmf_pkg::OFF_W'(1) : off_base;
  end

  assign pop_empty  = stored_count == '0;
  assign pop_len    = length_store[head_slot];
  assign stream_end = (rd_idx + owmf_pkg::OFF_W'(1)) == rd_len;

  // Result buffer space, counting a read still in flight
  assign o_pop     = (o_cnt != 2'd0) && rsp.ready;
  assign o_room    = (o_cnt != 2'd2) || o_pop;
  assign can_issue = (3'(o_cnt) + 3'(rd_pend)) < (3'd2 + 3'(o_pop));

  // Sequencer outputs
  always_comb begin
    cmd_ready = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    direct_we = 1'b0;
    issue     = 1'b0;
    unique case (state)
      owmf_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == owmf_pkg::CMD_PUSH) begin
            cmd_ready = 1'b1;
            do_push   = 1'b1;
          end else if (!rd_pend && o_room) begin
            cmd_ready = 1'b1;
            do_pop    = 1'b1;
            direct_we = pop_empty || (pop_len == '0);
          end
        end
      end
      owmf_pkg::BK_STREAM: begin
        issue = can_issue;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      owmf_pkg::BK_IDLE: begin
        if (do_pop && !direct_we) begin
          state_next = owmf_pkg::BK_STREAM;
        end
      end
      owmf_pkg::BK_STREAM: begin
        if (issue && stream_end) begin
          state_next = owmf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = owmf_pkg::BK_IDLE;
      end
    endcase
  end

  // Result written into the buffer: a fetched byte or a one-shot status
  always_comb begin
    o_we = direct_we || rd_pend;
    if (rd_pend) begin
      o_wdata.status     = owmf_pkg::STATUS_DATA;
      o_wdata.out_byte   = rd_data;
      o_wdata.out_valid  = 1'b1;
      o_wdata.msg_length = owmf_pkg::LEN_W'(rd_len);
      o_wdata.end_of_msg = rd_end;
    end else begin
      o_wdata.status     = pop_empty ? owmf_pkg::STATUS_EMPTY : owmf_pkg::STATUS_DATA;
      o_wdata.out_byte   = '0;
      o_wdata.out_valid  = 1'b0;
      o_wdata.msg_length = '0;
      o_wdata.end_of_msg = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= owmf_pkg::BK_IDLE;
      max_len      <= owmf_pkg::MAX_LEN_RESET;
      slots_used   <= owmf_pkg::SLOTS_RESET;
      head_slot    <= '0;
      tail_slot    <= '0;
      stored_count <= '0;
      write_offset <= '0;
      in_message   <= 1'b0;
      rd_pend      <= 1'b0;
      o_wp         <= 1'b0;
      o_rp         <= 1'b0;
      o_cnt        <= 2'd0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;

      if (cfg.valid) begin
        if (cfg.index == owmf_pkg::CFG_MAX_LEN) begin
          max_len <= cfg.data;
        end else if (cfg.index == owmf_pkg::CFG_SLOTS_USED) begin
          slots_used <= cfg.data[owmf_pkg::SLOTS_W-1:0];
        end
      end

      if (do_push) begin
        if (drop) begin
          head_slot <= head_drop;
        end
        if (cmd.last) begin
          tail_slot    <= owmf_pkg::next_slot(tail_slot);
          stored_count <= cnt_base + owmf_pkg::CNT_W'(1);
          in_message   <= 1'b0;
          write_offset <= '0;
        end else begin
          stored_count <= cnt_base;
          in_message   <= 1'b1;
          write_offset <= off_after;
        end
      end

      if (do_pop && !pop_empty) begin
        head_slot    <= owmf_pkg::next_slot(head_slot);
        stored_count <= stored_count - owmf_pkg::CNT_W'(1);
      end

      if (o_we) begin
        o_wp <= !o_wp;
      end
      if (o_pop) begin
        o_rp <= !o_rp;
      end
      o_cnt <= o_cnt + 2'(o_we) - 2'(o_pop);
    end
  end

  // Stream payload and length store
  always_ff @(posedge clk) begin
    if (do_push && cmd.last) begin
      length_store[tail_slot] <= off_after;
    end
    if (do_pop) begin
      rd_slot <= head_slot;
      rd_len  <= pop_len;
      rd_idx  <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + owmf_pkg::OFF_W'(1);
    end
    if (issue) begin
      rd_end <= stream_end;
    end
    if (o_we) begin
      o_buf[o_wp] <= o_wdata;
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_push && keep) begin
      byte_store[owmf_pkg::slot_addr(tail_slot, off_base)] <= cmd.data;
    end
    if (issue) begin
      rd_data <= byte_store[owmf_pkg::slot_addr(rd_slot, rd_idx)];
    end
  end

  assign rsp.valid      = o_cnt != 2'd0;
  assign rsp.status     = o_buf[o_rp].status;
  assign rsp.out_byte   = o_buf[o_rp].out_byte;
  assign rsp.out_valid  = o_buf[o_rp].out_valid;
  assign rsp.msg_length = o_buf[o_rp].msg_length;
  assign rsp.end_of_msg = o_buf[o_rp].end_of_msg;

endmodule

@@ rtl/core/overwrite_oldest_message_fifo.sv @@
// Message FIFO over a fixed pool of slots that drops the oldest message when full.
// Channels: req takes push and pop requests, rsp returns pop results, cfg writes
// max_len (index 0) and slots_used (index 1); write cfg only while the block is idle.
// A push request carries one byte (byte_valid) and/or the last flag that commits the
// message; a push request with neither is dropped at the front. Pushes give no result.
// A pop returns the oldest committed message, one result per byte with its length and
// end_of_msg on the final byte, or a single result for an empty queue (status 1) or a
// zero-length message.
// Timing: requests pass a holding register and a four-entry command queue; a pop's
// status-only result then passes the result buffer, and its first byte passes the
// stream state register, the byte store's single registered read port and the result
// buffer; bytes then follow one per cycle while the result buffer has room. During a
// pop's byte stream later requests wait in the queue.
// Pushes sustain one request per cycle while no pop holds the back end.
// Reset: the queue holds no message, max_len is 64 and slots_used is 8; the stores
// need no clearing pass.
// Stall: a two-entry result buffer absorbs rsp stalls; once it fills, the byte stream
// pauses, the command queue fills and req.ready drops.
module overwrite_oldest_message_fifo (
  input  logic        clk,
  input  logic        rst,
  owmf_cfg_if.sink    cfg,
  owmf_req_if.sink    req,
  owmf_rsp_if.source  rsp
);

  logic           f_valid;
  owmf_pkg::cmd_t f_cmd;
  logic           f_ready;
  logic           q_valid;
  owmf_pkg::cmd_t q_cmd;
  logic           q_ready;

  owmf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  owmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_cmd    (f_cmd),
    .in_ready  (f_ready),
    .out_valid (q_valid),
    .out_cmd   (q_cmd),
    .out_ready (q_ready)
  );

  owmf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .rsp       (rsp)
  );

  // An empty-queue result is a lone status with no byte and no length
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == owmf_pkg::STATUS_EMPTY)
      |-> rsp.end_of_msg && !rsp.out_valid && (rsp.msg_length == '0))
    else $error("empty result carries data");

  // A byte result belongs to a message of nonzero length
  a_byte_shape: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.out_valid
      |-> (rsp.status == owmf_pkg::STATUS_DATA) && (rsp.msg_length != '0))
    else $error("byte result without message length");

  // After a non-final byte is taken, the next result continues the same message
  a_stream_cont: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && rsp.out_valid && !rsp.end_of_msg ##1 rsp.valid
      |-> rsp.out_valid && (rsp.msg_length == $past(rsp.msg_length)))
    else $error("message stream broken");

  // Commands reach the back end only from a nonempty queue
  a_queue_feed: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> q_valid)
    else $error("command taken from empty queue");

endmodule
